FILE: src/cht_pkg.sv
// Package with the shared constants and types of the cuckoo hash table.
package cht_pkg;

    localparam int unsigned SLOTS    = 32;
    localparam int unsigned IDX_W    = $clog2(SLOTS);
    localparam int unsigned KEY_W    = 31;
    localparam int unsigned SIZE_W   = 6;
    localparam int unsigned QUO_W    = KEY_W;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIZE_W-1:0] t_size;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_MOVED    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_GAVE_UP  = 3'd2,
        ST_FOUND    = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_ABSENT   = 3'd5
    } t_status;

    typedef struct packed {
        logic    table_sel;
        t_idx    slot_index;
        t_key    key_out;
        t_status status;
        t_key    dropped_key;
        logic    last;
    } t_result;

    typedef struct packed {
        logic [1:0] op;
        t_key       key;
    } t_request;

    // Memory access request from the controller to the table store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic sel;
        t_idx idx;
        t_key wdata;
    } t_mem_req;

endpackage

FILE: src/cht_if.sv
// Valid/ready channel interface carrying one payload.
interface cht_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cuckoo_hash_table.sv
// Top level of the two-table cuckoo hash set with its request sequencer.
//
// Requests arrive on i_req as (op, key) transfers: op 0 inserts, 1 deletes,
// 2 looks up; op 3 is discarded with no result. Results leave on o_res, one
// transfer per table write for an insert (moved, then inserted or gave_up)
// and a single transfer for delete, lookup, or a zero key. The last result of
// each request carries last = 1. The table size register is written through
// i_cfg_we / i_cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. 0 acts as 1 and values above SLOTS act
// as SLOTS. Each slot access computes key div size and key mod size with a
// bit-serial divider, then reads the slot memory and, for an insert or a
// delete hit, writes it back. A step on table two divides twice. An insert
// alternates tables for up to size+1 steps. A lookup or delete gives its
// result after the table-one step on a table-one hit, and after the
// table-two step otherwise. One request is worked on at a time. After reset
// the sequencer holds off requests while both memories are swept to zero. A
// result waits in the output register when the receiver stalls, and the
// sequencer waits with it before it evaluates its next table read.
module cuckoo_hash_table
    import cht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  t_size i_cfg_data,
    cht_if.sink   i_req,
    cht_if.source o_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_READ, S_EVAL, S_EMIT
    } t_state;

    t_state   r_state;
    t_size    r_cfg;
    t_size    r_n;
    logic [1:0] r_op;
    t_key     r_key;
    t_key     r_cur;
    logic     r_sel;
    t_idx     r_idx;
    t_size    r_kicks;
    t_size    r_kick_count;
    logic     r_out_valid;
    t_result  r_out;
    logic     r_div_stage;
    logic     r_start;

    t_key     w_quo;
    t_size    w_rem;
    logic     w_done;
    t_key     w_rdata;
    logic     w_clear_busy;
    t_mem_req w_mem;
    t_size    w_eff;
    t_key     w_div_in;

    assign w_eff = (r_cfg == '0) ? t_size'(1) :
                   (r_cfg > t_size'(SLOTS)) ? t_size'(SLOTS) : r_cfg;

    // The second table index needs (key div n) mod n, so a second pass divides
    // the first quotient again.
    assign w_div_in = r_div_stage ? w_quo : r_cur;

    cht_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_dividend  (w_div_in),
        .i_divisor   (r_n),
        .o_done      (w_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    cht_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_mem),
        .o_rdata      (w_rdata),
        .o_clear_busy (w_clear_busy)
    );

    always_comb begin
        w_mem = '0;
        w_mem.sel = r_sel;
        w_mem.idx = r_idx;
        if (r_state == S_READ) begin
            w_mem.rd_en = 1'b1;
        end else if (r_state == S_EVAL) begin
            if (r_op == OP_INSERT) begin
                w_mem.wr_en = 1'b1;
                w_mem.wdata = r_cur;
            end else if (r_op == OP_DELETE && w_rdata == r_key) begin
                w_mem.wr_en = 1'b1;
                w_mem.wdata = '0;
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !w_clear_busy && !r_out_valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg        <= t_size'(32);
            r_out_valid  <= 1'b0;
            r_start      <= 1'b0;
            r_div_stage  <= 1'b0;
            r_kick_count <= '0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op  <= i_req.data.op;
                        r_key <= i_req.data.key;
                        r_cur <= i_req.data.key;
                        r_n   <= w_eff;
                        r_sel <= 1'b0;
                        r_kicks <= '0;
                        r_div_stage <= 1'b0;
                        if (i_req.data.op == OP_NONE) begin
                            r_state <= S_IDLE;
                        end else if (i_req.data.key == '0) begin
                            r_out <= '{1'b0, '0, '0, ST_ABSENT, '0, 1'b1};
                            r_out_valid <= 1'b1;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        if (!r_sel) begin
                            r_idx   <= t_idx'(w_rem);
                            r_state <= S_READ;
                        end else if (!r_div_stage) begin
                            r_div_stage <= 1'b1;
                            r_start     <= 1'b1;
                        end else begin
                            r_div_stage <= 1'b0;
                            r_idx   <= t_idx'(w_rem);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // The evaluation overwrites the output register, so the
                    // previous result must have left first.
                    if (!r_out_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_op == OP_INSERT) begin
                        if (w_rdata == '0) begin
                            r_out <= '{r_sel, r_idx, r_cur, ST_INSERTED, '0, 1'b1};
                            r_kick_count <= r_kicks;
                            r_state <= S_EMIT;
                        end else if (r_kicks + 1'b1 > r_n) begin
                            r_out <= '{r_sel, r_idx, r_cur, ST_GAVE_UP, w_rdata, 1'b1};
                            r_kick_count <= r_kicks + 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_out <= '{r_sel, r_idx, r_cur, ST_MOVED, '0, 1'b0};
                            r_cur   <= w_rdata;
                            r_kicks <= r_kicks + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end else if (w_rdata == r_key) begin
                        r_out <= '{r_sel, r_idx, r_key,
                                   (r_op == OP_DELETE) ? ST_REMOVED : ST_FOUND,
                                   '0, 1'b1};
                        r_state <= S_EMIT;
                    end else if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_start <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_out <= '{1'b0, '0, '0, ST_ABSENT, '0, 1'b1};
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Present the result, then continue the kick chain or finish.
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sel   <= ~r_sel;
                            r_start <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Kick count of the most recent insert, kept as block state.
    logic w_kick_unused;
    assign w_kick_unused = ^r_kick_count;
endmodule

FILE: src/cht_divider.sv
// Restoring divider producing key div size and key mod size, one bit per cycle.
module cht_divider
    import cht_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_key   i_dividend,
    input  t_size  i_divisor,
    output logic   o_done,
    output t_key   o_quotient,
    output t_size  o_remainder
);
    localparam int unsigned CNT_W = $clog2(KEY_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_key             r_quo, n_quo;
    logic [SIZE_W:0]  r_rem, n_rem;
    t_size            r_div;
    logic [SIZE_W:0]  w_trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        w_trial = {r_rem[SIZE_W-1:0], r_quo[KEY_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(KEY_W);
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_trial - {1'b0, r_div};
                n_quo = {r_quo[KEY_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[KEY_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[SIZE_W-1:0];
endmodule

FILE: src/cht_store.sv
// Two slot memories with a registered read port and a reset clearing sweep.
module cht_store
    import cht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_key     o_rdata,
    output logic     o_clear_busy
);
    t_key   r_mem0 [SLOTS];
    t_key   r_mem1 [SLOTS];
    t_key   r_rdata;
    logic   r_clearing;
    t_idx   r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == t_idx'(SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem0[r_clr_idx] <= '0;
            r_mem1[r_clr_idx] <= '0;
        end else if (i_req.wr_en) begin
            if (i_req.sel) begin
                r_mem1[i_req.idx] <= i_req.wdata;
            end else begin
                r_mem0[i_req.idx] <= i_req.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= i_req.sel ? r_mem1[i_req.idx] : r_mem0[i_req.idx];
        end
    end

    assign o_rdata      = r_rdata;
    assign o_clear_busy = r_clearing;
endmodule
